// ===== design/cdq_pkg.sv =====
// cdq_pkg: shared types and constants for the circular deque core
// depends on nothing; imported by cdq_engine, circular_deque_core and the testbench

package cdq_pkg;

    localparam int DEPTH       = 16;
    localparam int IDX_W       = $clog2(DEPTH);
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int WORD_W      = 32;
    localparam int ACT_W       = 3;
    localparam int STATUS_W    = 2;
    localparam int OCC_W       = 5;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 112;

    localparam logic [ACT_W-1:0] ACT_INS_FRONT = 3'd0;
    localparam logic [ACT_W-1:0] ACT_INS_REAR  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_DEL_FRONT = 3'd2;
    localparam logic [ACT_W-1:0] ACT_DEL_REAR  = 3'd3;

    localparam logic [STATUS_W-1:0] STATUS_DONE     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 2'd2;

    typedef enum logic
    {
        ST_IDLE,
        ST_DONE
    } eng_state_t;

    // ring store access issued by the engine
    typedef struct packed
    {
        logic              we;
        logic [IDX_W-1:0]  waddr;
        logic [WORD_W-1:0] wdata;
        logic              re;
        logic [IDX_W-1:0]  raddr;
    } mem_req_t;

    // one result, msb first; packs straight into m_tdata
    typedef struct packed
    {
        logic                     is_full;
        logic                     is_empty;
        logic [OCC_W-1:0]         occupancy;
        logic signed [WORD_W-1:0] rear_value;
        logic signed [WORD_W-1:0] front_value;
        logic signed [WORD_W-1:0] removed_value;
        logic [STATUS_W-1:0]      status;
    } result_t;

endpackage

// ===== design/cdq_ram.sv =====
// cdq_ram: generic single-write, single-read synchronous ram with registered read
// depends on nothing

module cdq_ram
#(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== design/cdq_engine.sv =====
// cdq_engine: pointer, count and end-word registers plus the request sequencer
// depends on cdq_pkg; drives the ring store through a mem_req_t

module cdq_engine
    import cdq_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [ACT_W-1:0]         in_action,
    input  logic signed [WORD_W-1:0] in_value,
    output mem_req_t                 mem_req,
    input  logic [WORD_W-1:0]        rd_data,
    output logic                     res_valid,
    input  logic                     res_ready,
    output result_t                  res
);

    eng_state_t          state_reg, state_next;
    logic [IDX_W-1:0]    front_idx_reg, front_idx_next;
    logic [IDX_W-1:0]    rear_idx_reg, rear_idx_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [WORD_W-1:0]   front_word_reg, front_word_next;
    logic [WORD_W-1:0]   rear_word_reg, rear_word_next;
    logic                load_front_reg, load_front_next;
    logic                load_rear_reg, load_rear_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [WORD_W-1:0]   removed_reg, removed_next;
    logic                is_empty;
    logic                is_full;

    function automatic logic [IDX_W-1:0] slot_after(input logic [IDX_W-1:0] i);
        slot_after = (i == IDX_W'(DEPTH - 1)) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [IDX_W-1:0] slot_before(input logic [IDX_W-1:0] i);
        slot_before = (i == '0) ? IDX_W'(DEPTH - 1) : i - 1'b1;
    endfunction

    assign is_empty = (count_reg == '0);
    assign is_full  = (count_reg == CNT_W'(DEPTH));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            front_idx_reg  <= '0;
            rear_idx_reg   <= '0;
            count_reg      <= '0;
            front_word_reg <= '0;
            rear_word_reg  <= '0;
            load_front_reg <= 1'b0;
            load_rear_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            front_idx_reg  <= front_idx_next;
            rear_idx_reg   <= rear_idx_next;
            count_reg      <= count_next;
            front_word_reg <= front_word_next;
            rear_word_reg  <= rear_word_next;
            load_front_reg <= load_front_next;
            load_rear_reg  <= load_rear_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg  <= status_next;
        removed_reg <= removed_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        front_idx_next  = front_idx_reg;
        rear_idx_next   = rear_idx_reg;
        count_next      = count_reg;
        front_word_next = front_word_reg;
        rear_word_next  = rear_word_reg;
        load_front_next = load_front_reg;
        load_rear_next  = load_rear_reg;
        status_next     = status_reg;
        removed_next    = removed_reg;
        mem_req         = '0;
        in_ready        = 1'b0;
        res_valid       = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    state_next      = ST_DONE;
                    status_next     = STATUS_DONE;
                    removed_next    = '0;
                    load_front_next = 1'b0;
                    load_rear_next  = 1'b0;
                    case (in_action)
                        ACT_INS_FRONT, ACT_INS_REAR:
                        begin
                            if (is_full)
                            begin
                                status_next = STATUS_OVERFLOW;
                            end
                            else
                            begin
                                count_next    = count_reg + 1'b1;
                                mem_req.we    = 1'b1;
                                mem_req.wdata = in_value;
                                if (is_empty)
                                begin
                                    // first word always lands in slot zero
                                    front_idx_next  = '0;
                                    rear_idx_next   = '0;
                                    mem_req.waddr   = '0;
                                    front_word_next = in_value;
                                    rear_word_next  = in_value;
                                end
                                else if (in_action == ACT_INS_FRONT)
                                begin
                                    front_idx_next  = slot_before(front_idx_reg);
                                    mem_req.waddr   = slot_before(front_idx_reg);
                                    front_word_next = in_value;
                                end
                                else
                                begin
                                    rear_idx_next  = slot_after(rear_idx_reg);
                                    mem_req.waddr  = slot_after(rear_idx_reg);
                                    rear_word_next = in_value;
                                end
                            end
                        end
                        ACT_DEL_FRONT, ACT_DEL_REAR:
                        begin
                            if (is_empty)
                            begin
                                status_next = STATUS_EMPTY;
                            end
                            else
                            begin
                                count_next   = count_reg - 1'b1;
                                removed_next = (in_action == ACT_DEL_FRONT) ?
                                               front_word_reg : rear_word_reg;
                                if (count_reg == CNT_W'(1))
                                begin
                                    front_idx_next  = '0;
                                    rear_idx_next   = '0;
                                    front_word_next = '0;
                                    rear_word_next  = '0;
                                end
                                else if (in_action == ACT_DEL_FRONT)
                                begin
                                    // new front word comes back from the ram next cycle
                                    front_idx_next  = slot_after(front_idx_reg);
                                    mem_req.re      = 1'b1;
                                    mem_req.raddr   = slot_after(front_idx_reg);
                                    load_front_next = 1'b1;
                                end
                                else
                                begin
                                    rear_idx_next  = slot_before(rear_idx_reg);
                                    mem_req.re     = 1'b1;
                                    mem_req.raddr  = slot_before(rear_idx_reg);
                                    load_rear_next = 1'b1;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    if (load_front_reg)
                    begin
                        front_word_next = rd_data;
                    end
                    if (load_rear_reg)
                    begin
                        rear_word_next = rd_data;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        res.status        = status_reg;
        res.removed_value = removed_reg;
        res.front_value   = load_front_reg ? rd_data : front_word_reg;
        res.rear_value    = load_rear_reg ? rd_data : rear_word_reg;
        res.occupancy     = OCC_W'(count_reg);
        res.is_empty      = is_empty;
        res.is_full       = is_full;
    end

endmodule

// ===== design/circular_deque_core.sv =====
// circular_deque_core: top level of the circular double-ended queue
// depends on cdq_pkg, cdq_engine and cdq_ram
//
// usage
//   s_tvalid/s_tready/s_tdata carry one request: an action (insert front,
//   insert rear, delete front, delete rear, observe) and a 32-bit word.
//   m_tvalid/m_tready/m_tdata return exactly one result per request: status,
//   removed word, front and rear words, occupancy and the empty/full flags,
//   all as they stand after the request.
//   a request passes through the engine's idle and done states: in the accept
//   cycle the pointers and count update and the ring ram is written or read;
//   in the done state the ram read data returns and the result moves into
//   the output register once that register is free. the engine takes no new
//   request until the result of the last one has left it.
//   a result waiting in the output register does not block the next request;
//   a second result waits inside the engine until the receiver takes the
//   first, and s_tready stays low meanwhile.
//   reset empties the deque and clears both pointers; ram contents are left
//   as they are and are never read before being written.

module circular_deque_core
    import cdq_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,  // action[2:0], value[34:3], zero pad
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata   // status[1:0], removed_value[33:2],
                                             // front_value[65:34], rear_value[97:66],
                                             // occupancy[102:98], is_empty[103],
                                             // is_full[104], zero pad
);

    mem_req_t          mem_req;
    logic [WORD_W-1:0] rd_data;
    logic              res_valid;
    logic              res_ready;
    result_t           res;
    logic              out_valid_reg, out_valid_next;
    result_t           out_reg;

    cdq_engine u_engine
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_action (s_tdata[ACT_W-1:0]),
        .in_value  (s_tdata[ACT_W+WORD_W-1:ACT_W]),
        .mem_req   (mem_req),
        .rd_data   (rd_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    cdq_ram
    #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    )
    u_ring
    (
        .clk   (clk),
        .we    (mem_req.we),
        .waddr (mem_req.waddr),
        .wdata (mem_req.wdata),
        .re    (mem_req.re),
        .raddr (mem_req.raddr),
        .rdata (rd_data)
    );

    assign res_ready = !out_valid_reg || m_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_ready)
        begin
            out_valid_next = res_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(OUT_TDATA_W - $bits(result_t))'(0), out_reg};

    // one request in flight at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted while previous one still in the engine");

    // an empty deque shows zero end words
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out_reg.is_empty) |->
            (out_reg.front_value == '0 && out_reg.rear_value == '0))
        else $error("empty deque reports nonzero end words");

    // full flag agrees with the occupancy
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (out_reg.is_full == (out_reg.occupancy == OCC_W'(DEPTH))))
        else $error("full flag disagrees with occupancy");

    // overflow only when full, empty status only when empty
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out_reg.status == STATUS_OVERFLOW) |-> out_reg.is_full)
        else $error("overflow reported on a deque that is not full");

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out_reg.status == STATUS_EMPTY) |->
            (out_reg.is_empty && out_reg.removed_value == '0))
        else $error("empty status on a deque that holds words");

endmodule

// ===== tb/sv/tb_circular_deque_core.sv =====
`timescale 1ns / 1ps
// tb_circular_deque_core: self-checking testbench for the circular deque core
// depends on cdq_pkg and circular_deque_core; drives requests and checks every result
// against a cycle-free model of the deque kept in the testbench

module tb_circular_deque_core
    import cdq_pkg::*;
();

    localparam logic [ACT_W-1:0] ACT_OBSERVE = 3'd4;
    localparam logic [ACT_W-1:0] ACT_RSVD5   = 3'd5;
    localparam logic [ACT_W-1:0] ACT_RSVD7   = 3'd7;

    localparam logic [WORD_W-1:0] W_MAX  = 32'h7fff_ffff;
    localparam logic [WORD_W-1:0] W_MIN  = 32'h8000_0000;
    localparam logic [WORD_W-1:0] W_ONES = 32'hffff_ffff;

    localparam int RANDOM_PER_PHASE = 135;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES     = 8;

    typedef struct {
        logic [ACT_W-1:0]    act;
        logic [WORD_W-1:0]   val;
        int                  reps;
        bit                  typed;
        logic [STATUS_W-1:0] t_status;
        logic [WORD_W-1:0]   t_removed;
        logic [WORD_W-1:0]   t_front;
        logic [WORD_W-1:0]   t_rear;
        logic [OCC_W-1:0]    t_occ;
    } dir_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;   // action[2:0], value[34:3], zero pad
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;   // status[1:0], removed_value[33:2],
                                       // front_value[65:34], rear_value[97:66],
                                       // occupancy[102:98], is_empty[103],
                                       // is_full[104], zero pad

    // deque model state
    logic [WORD_W-1:0] ring_words [DEPTH];
    logic [IDX_W-1:0]  head_slot;
    logic [IDX_W-1:0]  tail_slot;
    logic [CNT_W-1:0]  word_count;

    result_t pending_results [$];
    int      error_count;

    // typed expectation for the request currently offered
    bit      cur_typed;
    result_t cur_typed_res;

    int src_idle_pct;
    int sink_idle_pct;
    bit long_hold_req;

    // driver-side view of the fill level, used only to steer stimulus
    int sent_count;
    bit fill_dir;

    dir_row_t dir_table [13];

    circular_deque_core i_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic result_t apply_deque_op(input logic [ACT_W-1:0] act,
                                               input logic [WORD_W-1:0] val);
        result_t r;
        r = '0;
        r.status = STATUS_DONE;
        if (act == ACT_INS_FRONT || act == ACT_INS_REAR)
        begin
            if (word_count == CNT_W'(DEPTH))
            begin
                r.status = STATUS_OVERFLOW;
            end
            else
            begin
                // first word always lands in slot 0, whichever end it came in at
                if (word_count == '0)
                begin
                    head_slot     = '0;
                    tail_slot     = '0;
                    ring_words[0] = val;
                end
                else if (act == ACT_INS_FRONT)
                begin
                    head_slot             = head_slot - 1'b1;
                    ring_words[head_slot] = val;
                end
                else
                begin
                    tail_slot             = tail_slot + 1'b1;
                    ring_words[tail_slot] = val;
                end
                word_count = word_count + 1'b1;
            end
        end
        else if (act == ACT_DEL_FRONT || act == ACT_DEL_REAR)
        begin
            if (word_count == '0)
            begin
                r.status = STATUS_EMPTY;
            end
            else
            begin
                if (act == ACT_DEL_FRONT)
                begin
                    r.removed_value = ring_words[head_slot];
                    head_slot       = head_slot + 1'b1;
                end
                else
                begin
                    r.removed_value = ring_words[tail_slot];
                    tail_slot       = tail_slot - 1'b1;
                end
                word_count = word_count - 1'b1;
                if (word_count == '0)
                begin
                    head_slot = '0;
                    tail_slot = '0;
                end
            end
        end
        if (word_count != '0)
        begin
            r.front_value = ring_words[head_slot];
            r.rear_value  = ring_words[tail_slot];
        end
        r.occupancy = OCC_W'(word_count);
        r.is_empty  = (word_count == '0);
        r.is_full   = (word_count == CNT_W'(DEPTH));
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [WORD_W-1:0] want,
                                 input logic [WORD_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
            error_count++;
        end
    endtask

    // request capture, prediction and result checking
    always @(posedge clk)
    begin
        result_t want;
        result_t got;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                want = apply_deque_op(s_tdata[ACT_W-1:0], s_tdata[ACT_W +: WORD_W]);
                if (cur_typed)
                begin
                    want = cur_typed_res;
                end
                pending_results.push_back(want);
            end
            if (m_tvalid && m_tready)
            begin
                got = result_t'(m_tdata[$bits(result_t)-1:0]);
                if (pending_results.size() == 0)
                begin
                    $display("%0t: result with nothing expected, actual %h", $time, got);
                    error_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    compare_field("status", WORD_W'(want.status), WORD_W'(got.status));
                    compare_field("removed_value", want.removed_value, got.removed_value);
                    compare_field("front_value", want.front_value, got.front_value);
                    compare_field("rear_value", want.rear_value, got.rear_value);
                    compare_field("occupancy", WORD_W'(want.occupancy),
                                  WORD_W'(got.occupancy));
                    compare_field("is_empty", WORD_W'(want.is_empty), WORD_W'(got.is_empty));
                    compare_field("is_full", WORD_W'(want.is_full), WORD_W'(got.is_full));
                end
            end
        end
    end

    // receiver: random back-pressure, plus one long hold-off on request
    initial
    begin
        int k;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                m_tready <= 1'b0;
                for (k = 0; k < LONG_HOLD_CYCLES; k++)
                begin
                    @(negedge clk);
                end
            end
            else
            begin
                m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
            end
        end
    end

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_request(input logic [ACT_W-1:0] act, input logic [WORD_W-1:0] val);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_TDATA_W - ACT_W - WORD_W){1'b0}}, val, act};
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        @(negedge clk);
        if ((act == ACT_INS_FRONT || act == ACT_INS_REAR) && sent_count < DEPTH)
        begin
            sent_count++;
        end
        else if ((act == ACT_DEL_FRONT || act == ACT_DEL_REAR) && sent_count > 0)
        begin
            sent_count--;
        end
    endtask

    task automatic run_random(input int n);
        int i;
        int r;
        bit grow;
        bit side;
        logic [ACT_W-1:0]  act;
        logic [WORD_W-1:0] val;
        for (i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 8)
            begin
                // noise: observe or an undefined action code
                act = ACT_W'($urandom_range(ACT_OBSERVE, ACT_RSVD7));
            end
            else
            begin
                grow = (r < 20) ? !fill_dir : fill_dir;
                side = 1'($urandom_range(0, 1));
                if (grow)
                begin
                    act = side ? ACT_INS_REAR : ACT_INS_FRONT;
                end
                else
                begin
                    act = side ? ACT_DEL_REAR : ACT_DEL_FRONT;
                end
            end
            case ($urandom_range(0, 11))
                0: val = W_MAX;
                1: val = W_MIN;
                2: val = W_ONES;
                3: val = '0;
                default: val = $urandom;
            endcase
            send_request(act, val);
            // swing between full and empty so both boundaries get hit often
            if (sent_count == DEPTH && fill_dir && $urandom_range(0, 2) == 0)
            begin
                fill_dir = 1'b0;
            end
            else if (sent_count == 0 && !fill_dir && $urandom_range(0, 2) == 0)
            begin
                fill_dir = 1'b1;
            end
            else if ($urandom_range(0, 39) == 0)
            begin
                fill_dir = !fill_dir;
            end
        end
    endtask

    task automatic wait_all_results();
        while (pending_results.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    initial
    begin
        int i;
        int j;
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        error_count   = 0;
        cur_typed     = 1'b0;
        cur_typed_res = '0;
        src_idle_pct  = 28;
        sink_idle_pct = 63;
        long_hold_req = 1'b0;
        sent_count    = 0;
        fill_dir      = 1'b1;
        head_slot     = '0;
        tail_slot     = '0;
        word_count    = '0;
        for (i = 0; i < DEPTH; i++)
        begin
            ring_words[i] = '0;
        end

        dir_table = '{
            '{ACT_OBSERVE,   '0,     1, 1'b1, STATUS_DONE,     '0,    '0,     '0,    5'd0},
            '{ACT_DEL_FRONT, '0,     1, 1'b1, STATUS_EMPTY,    '0,    '0,     '0,    5'd0},
            '{ACT_DEL_REAR,  W_ONES, 1, 1'b1, STATUS_EMPTY,    '0,    '0,     '0,    5'd0},
            // rear insert into an empty deque must set the front too
            '{ACT_INS_REAR,  W_MAX,  1, 1'b1, STATUS_DONE,     '0,    W_MAX,  W_MAX, 5'd1},
            '{ACT_INS_FRONT, W_MIN,  1, 1'b1, STATUS_DONE,     '0,    W_MIN,  W_MAX, 5'd2},
            '{ACT_DEL_REAR,  '0,     1, 1'b1, STATUS_DONE,     W_MAX, W_MIN,  W_MIN, 5'd1},
            '{ACT_DEL_FRONT, '0,     1, 1'b1, STATUS_DONE,     W_MIN, '0,     '0,    5'd0},
            // fill both ways, front pointer wraps below slot 0
            '{ACT_INS_FRONT, W_ONES, 8, 1'b0, STATUS_DONE,     '0,    '0,     '0,    5'd0},
            '{ACT_INS_REAR,  '0,     8, 1'b0, STATUS_DONE,     '0,    '0,     '0,    5'd0},
            '{ACT_INS_FRONT, 32'd5,  1, 1'b1, STATUS_OVERFLOW, '0,    W_ONES, '0,    5'd16},
            '{ACT_INS_REAR,  W_MAX,  1, 1'b1, STATUS_OVERFLOW, '0,    W_ONES, '0,    5'd16},
            '{ACT_RSVD5,     W_MIN,  1, 1'b0, STATUS_DONE,     '0,    '0,     '0,    5'd0},
            '{ACT_RSVD7,     '0,     1, 1'b0, STATUS_DONE,     '0,    '0,     '0,    5'd0}
        };

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (i = 0; i < $size(dir_table); i++)
        begin
            for (j = 0; j < dir_table[i].reps; j++)
            begin
                cur_typed                   = dir_table[i].typed;
                cur_typed_res               = '0;
                cur_typed_res.status        = dir_table[i].t_status;
                cur_typed_res.removed_value = dir_table[i].t_removed;
                cur_typed_res.front_value   = dir_table[i].t_front;
                cur_typed_res.rear_value    = dir_table[i].t_rear;
                cur_typed_res.occupancy     = dir_table[i].t_occ;
                cur_typed_res.is_empty      = (dir_table[i].t_occ == 0);
                cur_typed_res.is_full       = (dir_table[i].t_occ == OCC_W'(DEPTH));
                send_request(dir_table[i].act, dir_table[i].val);
            end
        end
        cur_typed = 1'b0;
        fill_dir  = 1'b0;

        run_random(RANDOM_PER_PHASE);

        // sender holds off until everything outstanding is back
        s_tvalid <= 1'b0;
        wait_all_results();
        src_idle_pct  = 63;
        sink_idle_pct = 28;
        run_random(RANDOM_PER_PHASE);

        s_tvalid <= 1'b0;
        wait_all_results();
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        // long receiver stall while requests keep coming back to back
        long_hold_req = 1'b1;
        run_random(RANDOM_PER_PHASE);

        s_tvalid <= 1'b0;
        wait_all_results();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
